### hdl/rfcc_pkg.sv
// ---------------------------------------------------------------------------
// rfcc_pkg
// Shared types, constants and the CRC-8 step for the range frame checker.
// ---------------------------------------------------------------------------
package rfcc_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE = 2'd1;

	// Reset values of the bounds, millimetres
	localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 16'd200;
	localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 16'd14000;

	// Position of the next expected byte in a frame
	typedef enum logic [2:0] {
		POS_HIGH  = 3'b001,
		POS_LOW   = 3'b010,
		POS_CHECK = 3'b100
	} pos_t;

	// One finished reading
	typedef struct packed {
		logic [DIST_W-1:0] range_mm;
		logic              crc_ok;
		logic              in_range;
		logic              reading_valid;
	} rfcc_result_t;

	// One byte through CRC-8, MSB first, no reflection
	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
		input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### hdl/rfcc_if.sv
// ---------------------------------------------------------------------------
// rfcc_in_if / rfcc_out_if
// Valid/ready channels: frame bytes in, finished readings out.
// ---------------------------------------------------------------------------
interface rfcc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       first_byte;

	modport source (output valid, output rx_byte, output first_byte, input ready);
	modport sink   (input valid, input rx_byte, input first_byte, output ready);
endinterface

interface rfcc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] range_mm;
	logic        crc_ok;
	logic        in_range;
	logic        reading_valid;

	modport source (output valid, output range_mm, output crc_ok, output in_range,
		output reading_valid, input ready);
	modport sink   (input valid, input range_mm, input crc_ok, input in_range,
		input reading_valid, output ready);
endinterface

### hdl/rfcc_cfg.sv
// ---------------------------------------------------------------------------
// rfcc_cfg
// Distance bound registers behind the plain write port.
// ---------------------------------------------------------------------------
module rfcc_cfg
	import rfcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_wdata,
	output logic [DIST_W-1:0]    range_min_mm,
	output logic [DIST_W-1:0]    range_max_mm
);

	logic [DIST_W-1:0] min_q;
	logic [DIST_W-1:0] max_q;

	// Writes to unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_DISTANCE_RST;
			max_q <= MAX_DISTANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_DISTANCE: min_q <= cfg_wdata;
				REG_MAX_DISTANCE: max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign range_min_mm = min_q;
	assign range_max_mm = max_q;

endmodule

### hdl/rfcc_frame.sv
// ---------------------------------------------------------------------------
// rfcc_frame
// Frame position tracking, distance byte capture, running CRC-8 and the
// checks made on the check byte.
// ---------------------------------------------------------------------------
module rfcc_frame
	import rfcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic              first_byte,
	input  logic [DIST_W-1:0] range_min_mm,
	input  logic [DIST_W-1:0] range_max_mm,
	output logic              is_check,
	output rfcc_result_t      result
);

	pos_t              pos_q;
	pos_t              pos_eff;
	logic [BYTE_W-1:0] high_q;
	logic [BYTE_W-1:0] low_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] crc_base;
	logic [BYTE_W-1:0] crc_next;
	logic [DIST_W-1:0] dist_val;

	// First-byte flag restarts the frame wherever it stands
	assign pos_eff  = first_byte ? POS_HIGH : pos_q;
	assign is_check = (pos_eff == POS_CHECK);

	// CRC input: the running value on the low byte, else zero
	assign crc_base = (pos_eff == POS_LOW) ? crc_q : '0;
	assign crc_next = crc8_step(crc_base, rx_byte);

	// Position and CRC update per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HIGH;
			crc_q <= '0;
		end else if (step_en) begin
			case (pos_eff)
				POS_LOW: begin
					pos_q <= POS_CHECK;
					crc_q <= crc_next;
				end
				POS_CHECK: begin
					pos_q <= POS_HIGH;
					crc_q <= '0;
				end
				default: begin
					pos_q <= POS_LOW;
					crc_q <= crc_next;
				end
			endcase
		end
	end

	// Distance bytes
	always_ff @(posedge clk) begin
		if (step_en) begin
			if (pos_eff == POS_LOW) begin
				low_q <= rx_byte;
			end else if (pos_eff != POS_CHECK) begin
				high_q <= rx_byte;
			end
		end
	end

	// Checks on the check byte
	assign dist_val             = {high_q, low_q};
	assign result.range_mm      = dist_val;
	assign result.crc_ok        = (crc_q == rx_byte);
	assign result.in_range      = (dist_val > range_min_mm) && (dist_val < range_max_mm);
	assign result.reading_valid = result.crc_ok && result.in_range;

endmodule

### hdl/rfcc_out.sv
// ---------------------------------------------------------------------------
// rfcc_out
// Result register: holds one reading until the sink takes it.
// ---------------------------------------------------------------------------
module rfcc_out
	import rfcc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  rfcc_result_t result_in,
	input  logic         take,
	output logic         valid,
	output logic         free,
	output rfcc_result_t result_out
);

	logic         valid_s2;
	rfcc_result_t result_s2;

	assign free = !valid_s2 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			result_s2 <= result_in;
		end
	end

	assign valid      = valid_s2;
	assign result_out = result_s2;

endmodule

### hdl/range_frame_crc_checker.sv
// ---------------------------------------------------------------------------
// range_frame_crc_checker
// Checks three-byte range frames (distance high, distance low, CRC-8 byte)
// and emits one reading with CRC and range flags per complete frame.
// ---------------------------------------------------------------------------
//  channel   | dir | payload                                        | handshake
//  frame     | in  | rx_byte[7:0], first_byte                       | valid/ready
//  reading   | out | range_mm[15:0], crc_ok, in_range,              | valid/ready
//            |     | reading_valid                                  |
//  cfg       | in  | cfg_index[1:0], cfg_wdata[15:0]                | cfg_we
//
//  One beat per cycle unless stalled. A frame beat is held in the input register
//  and worked there; a check byte's reading is loaded into the result register
//  as the beat leaves the input register and is offered from then on.
//  Frame beats are stalled only while a check byte waits in the input
//  register and the result register is still held by the sink.
//  Reset clears frame position, CRC, bounds (200 / 14000 mm) and valid flags.
// ---------------------------------------------------------------------------
module range_frame_crc_checker
	import rfcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	rfcc_in_if.sink              frame,
	rfcc_out_if.source           reading,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_wdata
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic              is_check;
	logic              out_free;
	logic              adv_s1;
	logic [DIST_W-1:0] range_min_mm;
	logic [DIST_W-1:0] range_max_mm;
	rfcc_result_t      result_s1;
	rfcc_result_t      result_s2;

	// Input register advances unless a reading is blocked downstream
	assign adv_s1      = valid_s1 && (!is_check || out_free);
	assign frame.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1  <= frame.rx_byte;
			first_s1 <= frame.first_byte;
		end
	end

	rfcc_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.range_min_mm (range_min_mm),
		.range_max_mm (range_max_mm)
	);

	rfcc_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_en      (adv_s1),
		.rx_byte      (byte_s1),
		.first_byte   (first_s1),
		.range_min_mm (range_min_mm),
		.range_max_mm (range_max_mm),
		.is_check     (is_check),
		.result       (result_s1)
	);

	rfcc_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1 && is_check),
		.result_in  (result_s1),
		.take       (reading.ready),
		.valid      (reading.valid),
		.free       (out_free),
		.result_out (result_s2)
	);

	assign reading.range_mm      = result_s2.range_mm;
	assign reading.crc_ok        = result_s2.crc_ok;
	assign reading.in_range      = result_s2.in_range;
	assign reading.reading_valid = result_s2.reading_valid;

endmodule

### hdl/rfcc_checker.sv
// ---------------------------------------------------------------------------
// rfcc_checker
// Port-level checks on the range frame checker, bound to the top level.
// ---------------------------------------------------------------------------
module rfcc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        frame_ready,
	input logic        reading_valid_beat,
	input logic        reading_ready,
	input logic [15:0] range_mm,
	input logic        crc_ok,
	input logic        in_range,
	input logic        reading_valid
);

	// A stalled reading stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		reading_valid_beat && !reading_ready |=> reading_valid_beat)
		else $error("reading beat dropped while stalled");

	// A stalled reading keeps its payload
	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		reading_valid_beat && !reading_ready |=>
		$stable(range_mm) && $stable(crc_ok) && $stable(in_range)
		&& $stable(reading_valid))
		else $error("reading payload changed while stalled");

	// Combined flag follows both checks
	a_valid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		reading_valid_beat |-> (reading_valid == (crc_ok && in_range)))
		else $error("reading_valid disagrees with crc_ok and in_range");

	// Strict bounds exclude both end codes of the distance
	a_range_ends: assert property (@(posedge clk) disable iff (!arst_n)
		reading_valid_beat && in_range |-> (range_mm != 16'h0000)
		&& (range_mm != 16'hFFFF))
		else $error("in_range set on an end-of-scale distance");

	// Frame bytes flow whenever the reading side is not stalled
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(reading_valid_beat && !reading_ready) |-> frame_ready)
		else $error("frame stalled with free result register");

endmodule

bind range_frame_crc_checker rfcc_checker u_rfcc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.frame_ready        (frame.ready),
	.reading_valid_beat (reading.valid),
	.reading_ready      (reading.ready),
	.range_mm           (reading.range_mm),
	.crc_ok             (reading.crc_ok),
	.in_range           (reading.in_range),
	.reading_valid      (reading.reading_valid)
);

### sim/range_frame_crc_checker_tb.sv
// ---------------------------------------------------------------------------
// range_frame_crc_checker_tb
// Sends range frames (distance high, distance low, CRC-8 byte) into the frame
// channel and checks every reading against an in-bench predictor of the
// frame position, running CRC and bound compares. Directed frames cover the
// bound edges, frame restarts and unused register indexes. Random frames,
// mostly well formed with some corrupt, truncated or stray beats, then run
// under several bound settings, random gaps on both channels save in the last.
// ---------------------------------------------------------------------------
module range_frame_crc_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rfcc_pkg::*;

	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	// Indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIST_W-1:0]    cfg_wdata;

	rfcc_in_if  frame_if ();
	rfcc_out_if reading_if ();

	range_frame_crc_checker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_if),
		.reading   (reading_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Predictor state: frame position, captured bytes, CRC and bounds
	pos_t              frame_pos;
	logic [7:0]        dist_hi;
	logic [7:0]        dist_lo;
	logic [7:0]        frame_crc;
	logic [DIST_W-1:0] bound_min;
	logic [DIST_W-1:0] bound_max;
	rfcc_result_t      readings_due[$];
	rfcc_result_t      reading_want;

	// Run bookkeeping
	int unsigned cycle_count;
	int unsigned beats_sent;
	int unsigned beats_accepted;
	int unsigned readings_checked;
	int unsigned crc_bad_seen;
	int unsigned in_range_seen;
	int unsigned valid_seen;
	int unsigned bound_settings;
	int unsigned mismatches;
	int unsigned calm_left;
	bit          idle_on;
	bit          misaligned;

	// Clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d readings still due", cycle_count,
			readings_due.size());
		$display("FAIL range_frame_crc_checker");
		$finish;
	end

	// CRC-8, poly 0x07, fed one bit at a time MSB first
	function automatic logic [7:0] crc8_bitwise(input logic [7:0] crc_in,
		input logic [7:0] data);
		logic [7:0] acc;
		logic       fb;
		acc = crc_in;
		for (int i = 7; i >= 0; i--) begin
			fb  = acc[7] ^ data[i];
			acc = {acc[6:0], 1'b0};
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	// Advance the frame tracker by one accepted beat; queue a reading on the
	// check byte
	function automatic void track_frame_beat(input logic [7:0] rx, input logic restart);
		rfcc_result_t      r;
		logic [DIST_W-1:0] distance;
		if (restart) begin
			frame_pos = POS_HIGH;
			frame_crc = 8'h00;
		end
		case (frame_pos)
			POS_LOW: begin
				dist_lo   = rx;
				frame_crc = crc8_bitwise(frame_crc, rx);
				frame_pos = POS_CHECK;
			end
			POS_CHECK: begin
				distance        = {dist_hi, dist_lo};
				r.range_mm      = distance;
				r.crc_ok        = (frame_crc == rx);
				r.in_range      = (distance > bound_min) && (distance < bound_max);
				r.reading_valid = r.crc_ok & r.in_range;
				readings_due.push_back(r);
				frame_pos = POS_HIGH;
				frame_crc = 8'h00;
			end
			default: begin
				dist_hi   = rx;
				frame_crc = crc8_bitwise(8'h00, rx);
				frame_pos = POS_LOW;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want_v);
		$display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want_v);
		mismatches++;
	endtask

	// Frame beat monitor
	always @(posedge clk) begin
		if (arst_n && frame_if.valid && frame_if.ready) begin
			track_frame_beat(frame_if.rx_byte, frame_if.first_byte);
			beats_accepted++;
		end
	end

	// Reading checker
	always @(posedge clk) begin
		if (arst_n && reading_if.valid && reading_if.ready) begin
			if (readings_due.size() == 0) begin
				report_mismatch("reading with none due", 32'(reading_if.range_mm), 0);
			end else begin
				reading_want = readings_due.pop_front();
				readings_checked++;
				if (!reading_want.crc_ok) crc_bad_seen++;
				if (reading_want.in_range) in_range_seen++;
				if (reading_want.reading_valid) valid_seen++;
				if (reading_if.range_mm !== reading_want.range_mm)
					report_mismatch("range_mm", 32'(reading_if.range_mm),
						32'(reading_want.range_mm));
				if (reading_if.crc_ok !== reading_want.crc_ok)
					report_mismatch("crc_ok", 32'(reading_if.crc_ok),
						32'(reading_want.crc_ok));
				if (reading_if.in_range !== reading_want.in_range)
					report_mismatch("in_range", 32'(reading_if.in_range),
						32'(reading_want.in_range));
				if (reading_if.reading_valid !== reading_want.reading_valid)
					report_mismatch("reading_valid", 32'(reading_if.reading_valid),
						32'(reading_want.reading_valid));
			end
		end
	end

	// Reading sink: random stall bursts, always ready once idling is off
	initial begin
		reading_if.ready = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				reading_if.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			reading_if.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// One frame beat, with an optional gap in front; returns at the accepting edge
	task automatic send_beat(input logic [7:0] rx, input logic restart);
		int unsigned gap;
		if (calm_left > 0) begin
			calm_left--;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(8, 40);
		end else if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			frame_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_if.valid      <= 1'b1;
		frame_if.rx_byte    <= rx;
		frame_if.first_byte <= restart;
		@(posedge clk);
		while (!frame_if.ready) @(posedge clk);
		beats_sent++;
	endtask

	// Whole frame; corrupt flips one bit of the check byte
	task automatic send_frame(input logic [DIST_W-1:0] distance, input bit corrupt,
		input logic restart);
		logic [7:0] chk;
		chk = crc8_bitwise(crc8_bitwise(8'h00, distance[15:8]), distance[7:0]);
		if (corrupt) begin
			chk = chk ^ (8'h01 << $urandom_range(0, 7));
		end
		send_beat(distance[15:8], restart);
		send_beat(distance[7:0], 1'b0);
		send_beat(chk, 1'b0);
	endtask

	// Stop sending and let every due reading come out
	task automatic wait_drained();
		frame_if.valid <= 1'b0;
		@(posedge clk);
		while (readings_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_MIN_DISTANCE: bound_min = val;
			REG_MAX_DISTANCE: bound_max = val;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_bounds(input logic [DIST_W-1:0] lo, input logic [DIST_W-1:0] hi);
		wait_drained();
		write_cfg(REG_MIN_DISTANCE, lo);
		write_cfg(REG_MAX_DISTANCE, hi);
		bound_settings++;
	endtask

	// Distances cluster around the bounds and the ends of the range
	function automatic logic [DIST_W-1:0] pick_distance();
		case ($urandom_range(0, 9))
			0, 1:    return DIST_W'(bound_min - 16'd1 + $urandom_range(0, 2));
			2, 3:    return DIST_W'(bound_max - 16'd1 + $urandom_range(0, 2));
			4:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
			default: return DIST_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// Mostly good frames; some with a bad CRC, some cut short, some stray beats
	task automatic run_random_phase(input int unsigned beats);
		int unsigned       stop_at;
		int unsigned       pick;
		logic [DIST_W-1:0] distance;
		logic              restart;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 88) begin
				distance = pick_distance();
				restart  = misaligned ? 1'b1 : ($urandom_range(0, 1) == 1);
				send_frame(distance, pick >= 78, restart);
				misaligned = 1'b0;
			end else if (pick < 94) begin
				send_beat(8'($urandom_range(0, 255)), 1'b1);
				if ($urandom_range(0, 1) == 1) begin
					send_beat(8'($urandom_range(0, 255)), 1'b0);
				end
				misaligned = 1'b1;
			end else begin
				send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 1) == 1));
				misaligned = 1'b1;
			end
		end
	endtask

	// Reset bounds: both edges, back-to-back frames without restart, bad CRC
	task automatic test_default_bounds();
		send_frame(16'd200, 1'b0, 1'b1);
		send_frame(16'd201, 1'b0, 1'b0);
		send_frame(16'd13999, 1'b1, 1'b0);
		send_frame(16'd14000, 1'b0, 1'b1);
		wait_drained();
	endtask

	// Restart on the low byte and on the check byte position
	task automatic test_frame_restart();
		send_beat(8'hA5, 1'b1);
		send_beat(8'h12, 1'b1);
		send_beat(8'h34, 1'b0);
		send_beat(8'h56, 1'b1);
		send_beat(8'h78, 1'b0);
		send_beat(crc8_bitwise(crc8_bitwise(8'h00, 8'h56), 8'h78), 1'b0);
		wait_drained();
	endtask

	// Widest bounds with the extreme distances and all-ones bytes
	task automatic test_full_range();
		set_bounds(16'h0000, 16'hFFFF);
		send_frame(16'h0000, 1'b0, 1'b1);
		send_frame(16'h0001, 1'b0, 1'b0);
		send_frame(16'hFFFF, 1'b0, 1'b0);
		wait_drained();
	endtask

	// Writes to indexes with no register must leave the bounds alone
	task automatic test_spare_index();
		set_bounds(16'd3000, 16'd40000);
		write_cfg(REG_SPARE_A, DIST_W'($urandom_range(0, 65535)));
		write_cfg(REG_SPARE_B, DIST_W'($urandom_range(0, 65535)));
		run_random_phase(200);
	endtask

	task automatic test_random_reset_bounds();
		set_bounds(MIN_DISTANCE_RST, MAX_DISTANCE_RST);
		run_random_phase(250);
	endtask

	task automatic test_random_wide_open();
		set_bounds(16'h0000, 16'hFFFF);
		run_random_phase(250);
	endtask

	// Inverted bounds and min one below max: nothing is in range
	task automatic test_random_empty_range();
		set_bounds(16'hFFFF, 16'h0000);
		run_random_phase(125);
		set_bounds(16'd1000, 16'd1001);
		run_random_phase(125);
	endtask

	// Only one distance lies in range
	task automatic test_random_single_value();
		set_bounds(16'd1000, 16'd1002);
		run_random_phase(200);
	endtask

	task automatic test_random_bounds_sweep();
		repeat (4) begin
			set_bounds(DIST_W'($urandom_range(0, 65535)), DIST_W'($urandom_range(0, 65535)));
			run_random_phase(75);
		end
	endtask

	// Full rate on both channels
	task automatic test_random_no_idle();
		set_bounds(MIN_DISTANCE_RST, MAX_DISTANCE_RST);
		idle_on   = 1'b0;
		calm_left = 0;
		run_random_phase(250);
	endtask

	// Sequence
	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = REG_MIN_DISTANCE;
		cfg_wdata           = '0;
		frame_if.valid      = 1'b0;
		frame_if.rx_byte    = 8'h00;
		frame_if.first_byte = 1'b0;
		frame_pos           = POS_HIGH;
		dist_hi             = 8'h00;
		dist_lo             = 8'h00;
		frame_crc           = 8'h00;
		bound_min           = MIN_DISTANCE_RST;
		bound_max           = MAX_DISTANCE_RST;
		beats_sent          = 0;
		beats_accepted      = 0;
		readings_checked    = 0;
		crc_bad_seen        = 0;
		in_range_seen       = 0;
		valid_seen          = 0;
		bound_settings      = 1;
		mismatches          = 0;
		calm_left           = 0;
		idle_on             = 1'b1;
		misaligned          = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_bounds();
		test_frame_restart();
		test_full_range();
		test_spare_index();
		test_random_reset_bounds();
		test_random_wide_open();
		test_random_empty_range();
		test_random_single_value();
		test_random_bounds_sweep();
		test_random_no_idle();
		wait_drained();

		$display("covered %0d frame beats, %0d readings under %0d bound settings",
			beats_accepted, readings_checked, bound_settings);
		$display("readings: %0d CRC failures, %0d in range, %0d valid, %0d mismatches",
			crc_bad_seen, in_range_seen, valid_seen, mismatches);
		if (mismatches == 0) begin
			$display("PASS range_frame_crc_checker");
		end else begin
			$display("FAIL range_frame_crc_checker");
		end
		$finish;
	end

endmodule

### range_frame_crc_checker.f
hdl/rfcc_pkg.sv
hdl/rfcc_if.sv
hdl/rfcc_cfg.sv
hdl/rfcc_frame.sv
hdl/rfcc_out.sv
hdl/range_frame_crc_checker.sv
hdl/rfcc_checker.sv
sim/range_frame_crc_checker_tb.sv
